[rtl/core/backlight_autosleep_paced_writer_macros.svh]
// ----------------------------------------------------------------------------
// Backlight auto-sleep writer assertion macros
// Shared concurrent assertion forms for the backlight writer checkers.
// ----------------------------------------------------------------------------
`ifndef BACKLIGHT_AUTOSLEEP_PACED_WRITER_MACROS_SVH
`define BACKLIGHT_AUTOSLEEP_PACED_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLAPW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define BLAPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[rtl/core/blapw_pkg.sv]
// ----------------------------------------------------------------------------
// Backlight auto-sleep writer package
// Shared types, codes and constants of the backlight writer.
// ----------------------------------------------------------------------------
package blapw_pkg;

  localparam int unsigned WRITE_SPACING_MS_DEF = 250;

  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

  localparam logic [1:0] PEND_BOTH = 2'b11;
  localparam logic [1:0] PEND_LCD  = 2'b01;
  localparam logic [1:0] PEND_KBD  = 2'b10;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 1;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_APPLY = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISP_LEVEL    = 2'd0,
    REG_KEYS_LEVEL    = 2'd1,
    REG_SLEEP_MINUTES = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  disp_level;
    logic [7:0]  keys_level;
    logic [31:0] sleep_threshold;  // sleep_minutes * 60000, zero disables
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic        key_pressed;
    logic        bus_free;
  } item_t;

  typedef struct packed {
    logic       swallow_key;
    logic       is_asleep;
    logic       write_valid;
    logic       write_target;
    logic [7:0] write_level;
  } result_t;

endpackage

[rtl/core/blapw_cfg.sv]
// ----------------------------------------------------------------------------
// Backlight writer configuration registers
// Holds the backlight levels and the precomputed sleep threshold in ms.
// ----------------------------------------------------------------------------
module blapw_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [blapw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blapw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output blapw_pkg::cfg_t                      cfg
);

  logic [31:0] threshold_next;

  // Minutes fit in 16 bits, so the product always fits in 32.
  assign threshold_next = {16'd0, cfg_data} * blapw_pkg::MS_PER_MINUTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        blapw_pkg::REG_DISP_LEVEL:    cfg.disp_level <= cfg_data[7:0];
        blapw_pkg::REG_KEYS_LEVEL:    cfg.keys_level <= cfg_data[7:0];
        blapw_pkg::REG_SLEEP_MINUTES: cfg.sleep_threshold <= threshold_next;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/blapw_step.sv]
// ----------------------------------------------------------------------------
// Backlight writer step logic
// Sleep/wake state, pending writes and write pacing for one transaction.
// ----------------------------------------------------------------------------
module blapw_step #(
  parameter int unsigned WRITE_SPACING_MS = blapw_pkg::WRITE_SPACING_MS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  blapw_pkg::item_t   item,
  input  blapw_pkg::cfg_t    cfg,
  output blapw_pkg::result_t result
);

  localparam logic [31:0] SPACING = 32'(WRITE_SPACING_MS);

  logic        sleeping,       sleeping_next;
  logic        activity_seen,  activity_seen_next;
  logic [31:0] last_activity,  last_activity_next;
  logic [1:0]  pending,        pending_next;
  logic [31:0] last_write,     last_write_next;

  logic [31:0] act_eff;
  logic [31:0] idle_ms;
  logic [31:0] since_write;

  assign act_eff     = activity_seen ? last_activity : item.now_ms;
  assign idle_ms     = item.now_ms - act_eff;
  assign since_write = item.now_ms - last_write;

  always_comb begin
    sleeping_next      = sleeping;
    activity_seen_next = activity_seen;
    last_activity_next = last_activity;
    pending_next       = pending;
    last_write_next    = last_write;
    result             = '0;

    unique case (item.kind)
      blapw_pkg::KIND_KEY: begin
        last_activity_next = item.now_ms;
        activity_seen_next = 1'b1;
        if (sleeping && item.key_pressed) begin
          sleeping_next      = 1'b0;
          pending_next       = blapw_pkg::PEND_BOTH;
          result.swallow_key = 1'b1;
        end
      end
      blapw_pkg::KIND_APPLY: begin
        pending_next = blapw_pkg::PEND_BOTH;
      end
      blapw_pkg::KIND_TICK: begin
        // first tick counts as boot activity
        last_activity_next = act_eff;
        activity_seen_next = 1'b1;
        if (!sleeping && (cfg.sleep_threshold != '0) && (idle_ms >= cfg.sleep_threshold)) begin
          sleeping_next = 1'b1;
          pending_next  = blapw_pkg::PEND_BOTH;
        end
        if ((pending_next != '0) && item.bus_free && (since_write >= SPACING)) begin
          result.write_valid = 1'b1;
          last_write_next    = item.now_ms;
          if ((pending_next & blapw_pkg::PEND_LCD) != '0) begin
            result.write_target = 1'b0;
            result.write_level  = sleeping_next ? 8'd0 : cfg.disp_level;
            pending_next        = pending_next & blapw_pkg::PEND_KBD;
          end else begin
            result.write_target = 1'b1;
            result.write_level  = sleeping_next ? 8'd0 : cfg.keys_level;
            pending_next        = '0;
          end
        end
      end
      default: ;  // unused kind: no state change
    endcase

    result.is_asleep = sleeping_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleeping      <= 1'b0;
      activity_seen <= 1'b0;
      last_activity <= '0;
      pending       <= '0;
      last_write    <= '0;
    end else if (step_en) begin
      sleeping      <= sleeping_next;
      activity_seen <= activity_seen_next;
      last_activity <= last_activity_next;
      pending       <= pending_next;
      last_write    <= last_write_next;
    end
  end

endmodule

[rtl/core/backlight_autosleep_paced_writer.sv]
// ----------------------------------------------------------------------------
// Backlight auto-sleep paced writer
// Auto power-down of the backlights with paced level writes to the bus.
// ----------------------------------------------------------------------------
// One result transaction comes out for every input transaction, in order.
// Throughput is one transaction per clock while m_tready does not stall the
// result register. An accepted transaction waits in the input register until
// the result register is free; at that edge the state is updated and the
// result register loaded, and the result is then presented on the master
// side until it is taken. The step logic updates its state once per
// transaction, so each transaction sees the state left by the one before it.
// Configuration writes take effect in the cycle after cfg_we; the sleep
// threshold (minutes * 60000 ms) is computed at write time, so the
// per-transaction path is only a couple of 32-bit subtract/compares and muxes.
module backlight_autosleep_paced_writer #(
  parameter int unsigned WRITE_SPACING_MS = blapw_pkg::WRITE_SPACING_MS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [31:0] now_ms, [32] key_pressed, [33] bus_free, [39:34] zero
  input  logic [blapw_pkg::IN_DATA_W-1:0]      s_tdata,
  // [1:0] kind
  input  logic [blapw_pkg::IN_USER_W-1:0]      s_tuser,
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] swallow_key, [1] is_asleep, [2] write_valid, [10:3] write_level,
  // [15:11] zero
  output logic [blapw_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [0] write_target
  output logic [blapw_pkg::OUT_USER_W-1:0]     m_tuser,
  // configuration
  input  logic                                 cfg_we,
  input  logic [blapw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blapw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  blapw_pkg::cfg_t    cfg;
  blapw_pkg::item_t   in_item;
  blapw_pkg::result_t step_result;
  blapw_pkg::result_t out_result;

  logic in_valid;
  logic out_free;
  logic advance;
  logic in_take;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign in_take  = s_tvalid && s_tready;

  blapw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.kind        <= s_tuser[1:0];
      in_item.now_ms      <= s_tdata[31:0];
      in_item.key_pressed <= s_tdata[32];
      in_item.bus_free    <= s_tdata[33];
    end
  end

  // State update happens exactly when the transaction moves to the output.
  blapw_step #(
    .WRITE_SPACING_MS (WRITE_SPACING_MS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {5'd0, out_result.write_level, out_result.write_valid,
                    out_result.is_asleep, out_result.swallow_key};
  assign m_tuser = out_result.write_target;

endmodule

[rtl/core/blapw_checker.sv]
// ----------------------------------------------------------------------------
// Backlight writer port checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "backlight_autosleep_paced_writer_macros.svh"

module blapw_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [blapw_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [blapw_pkg::OUT_USER_W-1:0]     m_tuser
);

  // A stalled result transaction holds.
  `BLAPW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // No write issued: target and level are zero.
  `BLAPW_ASSERT_NOW(a_nowrite_zero, clk, rst, m_tvalid && !m_tdata[2], (m_tdata[10:3] == 8'd0) && (m_tuser == 1'b0))

  // A swallowed wake press always leaves the block awake.
  `BLAPW_ASSERT_NOW(a_swallow_awake, clk, rst, m_tvalid && m_tdata[0], !m_tdata[1])

  // Writes while asleep drive the backlight off.
  `BLAPW_ASSERT_NOW(a_sleep_dark, clk, rst, m_tvalid && m_tdata[2] && m_tdata[1], m_tdata[10:3] == 8'd0)

endmodule

bind backlight_autosleep_paced_writer blapw_checker u_blapw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Backlight auto-sleep paced writer testbench
// Drives tick, key, apply and reserved-kind transactions through the stream
// input and checks every output transaction against an in-bench prediction
// of sleep entry, wake presses and paced display/keyboard level writes.
// The run covers several level and timeout settings and four idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import blapw_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 178;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned DRAIN_CYCLES    = 3;   // margin after the last outcome is checked
  localparam int unsigned TAIL_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS     = 10;

  // kind value outside the package enum; the block must treat it as a no-op
  localparam logic [1:0] KIND_RSVD = 2'd3;
  // register index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // DUT ports; all DUT inputs driven to known values from time zero
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata   = '0;
  logic [IN_USER_W-1:0]   s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  backlight_autosleep_paced_writer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [31:0] now_ms, [32] key_pressed, [33] bus_free
    .s_tuser   (s_tuser),    // [1:0] kind
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [0] swallow, [1] asleep, [2] write_valid, [10:3] level
    .m_tuser   (m_tuser),    // [0] write_target
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: configuration and state as the block should hold it
  // --------------------------------------------------------------------------
  logic [7:0]  cf_lcd     = '0;
  logic [7:0]  cf_kbd     = '0;
  logic [15:0] cf_minutes = '0;

  logic        bl_asleep   = 1'b0;
  logic [31:0] bl_act_time = '0;
  logic        bl_act_seen = 1'b0;
  logic [1:0]  bl_pend     = '0;
  logic [31:0] bl_last_wr  = '0;

  // outcomes still owed by the DUT, oldest first
  result_t writer_outcomes[$];

  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned n_items    = 0;
  int unsigned n_writes   = 0;
  int unsigned n_sleeps   = 0;
  int unsigned n_wakes    = 0;
  int unsigned n_settings = 0;

  // idling mix of the current phase, in percent
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;

  // running uptime for generated transactions
  logic [31:0] t_now = '0;

  // One transaction through the shadow state; returns the outcome it causes.
  function automatic result_t advance_backlight(item_t it);
    result_t     res;
    logic [31:0] thresh;
    res    = '0;
    thresh = {16'd0, cf_minutes} * MS_PER_MINUTE;
    if (it.kind == KIND_KEY) begin
      bl_act_time = it.now_ms;
      bl_act_seen = 1'b1;
      if (bl_asleep && it.key_pressed) begin
        // wake press: back to awake, both levels rewritten, key eaten
        bl_asleep       = 1'b0;
        bl_pend         = PEND_BOTH;
        res.swallow_key = 1'b1;
        n_wakes++;
      end
    end else if (it.kind == KIND_APPLY) begin
      bl_pend = PEND_BOTH;
    end else if (it.kind == KIND_TICK) begin
      // boot counts as activity on the first tick
      if (!bl_act_seen) begin
        bl_act_time = it.now_ms;
        bl_act_seen = 1'b1;
      end
      if (!bl_asleep && thresh != 32'd0 && (it.now_ms - bl_act_time) >= thresh) begin
        bl_asleep = 1'b1;
        bl_pend   = PEND_BOTH;
        n_sleeps++;
      end
      if (bl_pend != 2'b00 && it.bus_free &&
          (it.now_ms - bl_last_wr) >= 32'(WRITE_SPACING_MS_DEF)) begin
        res.write_valid = 1'b1;
        if ((bl_pend & PEND_LCD) != 2'b00) begin
          res.write_target = 1'b0;
          res.write_level  = bl_asleep ? 8'd0 : cf_lcd;
          bl_pend          = bl_pend & PEND_KBD;
        end else begin
          res.write_target = 1'b1;
          res.write_level  = bl_asleep ? 8'd0 : cf_kbd;
          bl_pend          = 2'b00;
        end
        bl_last_wr = it.now_ms;
        n_writes++;
      end
    end
    // reserved kind falls through: only the sleep flag is reported
    res.is_asleep = bl_asleep;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: reset config is replaced by lcd=FF, kbd=5A, 1 minute.
  // Rows with typed=1 carry an outcome read straight off the rules; the rest
  // take the shadow prediction.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic        pressed;
    logic        idle;
    logic        typed;
    logic        r_swallow;
    logic        r_asleep;
    logic        r_wvalid;
    logic        r_target;
    logic [7:0]  r_level;
  } row_t;

  localparam int unsigned NUM_ROWS = 24;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // first tick seeds the activity time, nothing pending
    '{KIND_TICK,  32'd0,        1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_APPLY, 32'd100,      1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    // spacing not reached, then bus busy, then display write at exactly 250
    '{KIND_TICK,  32'd200,      1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd250,      1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd250,      1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF},
    '{KIND_TICK,  32'd499,      1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd500,      1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h5A},
    '{KIND_TICK,  32'd1000,     1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    // key activity while awake: no swallow
    '{KIND_KEY,   32'd1000,     1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_KEY,   32'd1000,     1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    // one short of the timeout, then exactly at it with the bus busy
    '{KIND_TICK,  32'd60999,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd61000,    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
    // release while asleep does not wake
    '{KIND_KEY,   32'd61100,    1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
    // asleep: display written with zero
    '{KIND_TICK,  32'd61200,    1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00},
    // wake press is swallowed
    '{KIND_KEY,   32'd61300,    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd61400,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    // reserved kind changes nothing
    '{KIND_RSVD,  32'd61450,    1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd61450,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF},
    // apply restarts the pair from the display side
    '{KIND_APPLY, 32'd61500,    1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'd61700,    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF},
    // time near the top of the range, then wrapped elapsed time
    '{KIND_TICK,  32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'h0000_00EA, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_KEY,   32'h0000_0100, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_TICK,  32'h0000_01E4, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF}
  };

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One register write per clock; the shadow follows at the same moment.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_DISP_LEVEL:    cf_lcd     = data[7:0];
      REG_KEYS_LEVEL:    cf_kbd     = data[7:0];
      REG_SLEEP_MINUTES: cf_minutes = data;
      default: ;
    endcase
  endtask

  // Full setting; upper data bits of 8-bit registers carry junk on purpose.
  task automatic load_setting(logic [7:0] lcd, logic [7:0] kbd, logic [15:0] minutes);
    write_reg(REG_NONE, 16'($urandom()));
    write_reg(REG_DISP_LEVEL, {8'($urandom()), lcd});
    write_reg(REG_KEYS_LEVEL, {8'($urandom()), kbd});
    write_reg(REG_SLEEP_MINUTES, minutes);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // Present one transaction and hold it until accepted; queue its outcome.
  task automatic send_item(item_t it, logic typed, result_t typed_res);
    result_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, it.bus_free, it.key_pressed, it.now_ms};
    s_tuser  <= it.kind;
    do @(posedge clk); while (!s_tready);
    pred = advance_backlight(it);
    writer_outcomes.push_back(typed ? typed_res : pred);
    n_items++;
  endtask

  // Stop sending right at the last accept and wait until nothing is in flight.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (writer_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed;
    item_t   it;
    result_t res;
    for (int i = 0; i < NUM_ROWS; i++) begin
      it.kind          = DIRECTED[i].kind;
      it.now_ms        = DIRECTED[i].now;
      it.key_pressed   = DIRECTED[i].pressed;
      it.bus_free      = DIRECTED[i].idle;
      res.swallow_key  = DIRECTED[i].r_swallow;
      res.is_asleep    = DIRECTED[i].r_asleep;
      res.write_valid  = DIRECTED[i].r_wvalid;
      res.write_target = DIRECTED[i].r_target;
      res.write_level  = DIRECTED[i].r_level;
      send_item(it, DIRECTED[i].typed, res);
    end
    t_now = DIRECTED[NUM_ROWS-1].now;
  endtask

  // Mostly plausible traffic: time moves forward in small steps, with jumps
  // that land around the sleep timeout and a little fully random time.
  task automatic run_random(int unsigned count);
    item_t       it;
    int unsigned r;
    logic [31:0] thresh;
    for (int unsigned n = 0; n < count; n++) begin
      thresh = {16'd0, cf_minutes} * MS_PER_MINUTE;
      r = $urandom_range(99);
      if (r < 58)      it.kind = KIND_TICK;
      else if (r < 76) it.kind = KIND_KEY;
      else if (r < 90) it.kind = KIND_APPLY;
      else if (r < 95) it.kind = KIND_RSVD;
      else             it.kind = 2'($urandom());
      r = $urandom_range(99);
      if (r < 62)
        t_now = t_now + $urandom_range(300);
      else if (r < 78)
        t_now = t_now + $urandom_range(40);
      else if (r < 92 && thresh != 32'd0)
        t_now = bl_act_time + thresh + $urandom_range(600) - 32'd300;
      else if (r < 96)
        t_now = $urandom();
      it.now_ms      = t_now;
      it.key_pressed = ($urandom_range(99) < 60);
      it.bus_free    = ($urandom_range(99) < 80);
      send_item(it, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random backpressure and in-order checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_outputs
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.swallow_key  = m_tdata[0];
      got.is_asleep    = m_tdata[1];
      got.write_valid  = m_tdata[2];
      got.write_level  = m_tdata[10:3];
      got.write_target = m_tuser[0];
      if (writer_outcomes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"[%0t] unexpected output transaction ",
                    "swallow=%b asleep=%b wv=%b tgt=%b lvl=%h"},
                   $realtime, got.swallow_key, got.is_asleep, got.write_valid,
                   got.write_target, got.write_level);
      end else begin
        want = writer_outcomes.pop_front();
        if (got.swallow_key  !== want.swallow_key  ||
            got.is_asleep    !== want.is_asleep    ||
            got.write_valid  !== want.write_valid  ||
            got.write_target !== want.write_target ||
            got.write_level  !== want.write_level) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"[%0t] mismatch: swallow %b/%b asleep %b/%b wv %b/%b ",
                      "tgt %b/%b lvl %h/%h (expected/actual)"},
                     $realtime, want.swallow_key, got.swallow_key,
                     want.is_asleep, got.is_asleep, want.write_valid, got.write_valid,
                     want.write_target, got.write_target, want.write_level, got.write_level);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outcomes outstanding",
               cycles, writer_outcomes.size());
      $display("** backlight_autosleep_paced_writer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with no idling
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    load_setting(8'hFF, 8'h5A, 16'd1);
    run_directed();
    drain();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      // idling mix cycles through: none, sender, receiver, both lightly
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      case (ph)
        0: load_setting(8'h00, 8'hFF, 16'd0);         // auto power down off
        1: load_setting(8'hFF, 8'h00, 16'd1);
        2: load_setting(8'($urandom()), 8'($urandom()), 16'hFFFF);
        3: load_setting(8'($urandom()), 8'($urandom()), 16'($urandom_range(5, 1)));
        4: load_setting(8'($urandom()), 8'($urandom()), 16'($urandom_range(65535, 1)));
        5: load_setting(8'hFF, 8'hFF, 16'd1);
        6: load_setting(8'($urandom()), 8'($urandom()), 16'd2);
        default: load_setting(8'($urandom()), 8'($urandom()), 16'($urandom()));
      endcase
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (writer_outcomes.size() != 0) errors++;

    $display("covered %0d transactions under %0d settings and four idling mixes",
             n_items, n_settings);
    $display("  %0d level writes, %0d sleep entries, %0d swallowed wake presses, %0d errors",
             n_writes, n_sleeps, n_wakes, errors);
    if (errors == 0) begin
      $display("** backlight_autosleep_paced_writer: PASSED **");
    end else begin
      $display("** backlight_autosleep_paced_writer: FAILED **");
    end
    $finish;
  end

endmodule
